// File: hdl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and helpers of the serial command frame receiver.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam int SHORT_FRAME_LEN_DEF = 8;
    localparam int LONG_FRAME_LEN_DEF  = 32;
    localparam int MIN_FRAME_LEN       = 3;

    localparam logic [7:0]  LONG_CMD_MIN      = 8'h80;
    localparam logic [7:0]  START_MARKER_RST  = 8'd187;
    localparam logic [7:0]  END_MARKER_RST    = 8'd13;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

    localparam logic [1:0] REG_START_MARKER  = 2'd0;
    localparam logic [1:0] REG_END_MARKER    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] STAT_FRAME   = 2'd0;
    localparam logic [1:0] STAT_BAD_END = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       store_wr;
        logic       wp_inc;
        logic       long_load;
        logic       timer_restart;
        logic       timer_tick;
        logic       abort;
        logic [1:0] abort_code;
        logic       emit_start;
        logic       go_idle;
    } cmd_t;

    typedef struct packed {
        logic byte_is_start;
        logic byte_is_end;
        logic start_to_end;
        logic payload_last;
        logic timeout;
        logic emit_done;
        logic out_free;
    } stat_t;

    function automatic int clamp_len(input int len);
        int res;
        res = len;
        if (len < MIN_FRAME_LEN) res = MIN_FRAME_LEN;
        if (len > STORE_DEPTH) res = STORE_DEPTH;
        return res;
    endfunction

endpackage

// File: hdl/scf_regs.sv
// ----------------------------------------------------------------------------
// scf_regs
// Register bank behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module scf_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scf_pkg::PADDR_W-1:0] paddr,
    input  logic [scf_pkg::PDATA_W-1:0] pwdata,
    output logic [scf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output scf_pkg::cfg_t               cfg
);
    import scf_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_START_MARKER:  cfg_next.start_marker  = pwdata[7:0];
                REG_END_MARKER:    cfg_next.end_marker    = pwdata[7:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_MARKER:  prdata = {24'd0, cfg_reg.start_marker};
            REG_END_MARKER:    prdata = {24'd0, cfg_reg.end_marker};
            REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_reg.timeout_ticks};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker  <= START_MARKER_RST;
            cfg_reg.end_marker    <= END_MARKER_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/scf_ctrl.sv
// ----------------------------------------------------------------------------
// scf_ctrl
// Receive phase state machine; issues commands to the datapath.
// ----------------------------------------------------------------------------
module scf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           op,
    output logic           in_stall,
    input  scf_pkg::stat_t st,
    output scf_pkg::cmd_t  cmd
);
    import scf_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_START   = 3'd1;
    localparam logic [2:0] ST_PAYLOAD = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;
    logic       byte_acc;
    logic       tick_acc;

    assign in_stall = (state_reg == ST_EMIT) || !st.out_free;
    assign accept   = in_valid && !in_stall;
    assign byte_acc = accept && (op == OP_BYTE);
    assign tick_acc = accept && (op == OP_TICK);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (byte_acc && st.byte_is_start)
                begin
                    cmd.store_wr      = 1'b1;
                    cmd.wp_inc        = 1'b1;
                    cmd.timer_restart = 1'b1;
                    state_next        = ST_START;
                end
            end
            ST_START:
            begin
                if (byte_acc)
                begin
                    cmd.store_wr      = 1'b1;
                    cmd.wp_inc        = 1'b1;
                    cmd.long_load     = 1'b1;
                    cmd.timer_restart = 1'b1;
                    state_next        = st.start_to_end ? ST_END : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (byte_acc)
                begin
                    cmd.store_wr      = 1'b1;
                    cmd.wp_inc        = 1'b1;
                    cmd.timer_restart = 1'b1;
                    if (st.payload_last)
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                if (byte_acc)
                begin
                    if (st.byte_is_end)
                    begin
                        cmd.store_wr   = 1'b1;
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        cmd.abort      = 1'b1;
                        cmd.abort_code = STAT_BAD_END;
                        cmd.go_idle    = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (st.emit_done)
                begin
                    cmd.go_idle = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                cmd.go_idle = 1'b1;
                state_next  = ST_IDLE;
            end
        endcase

        if (tick_acc)
        begin
            cmd.timer_tick = 1'b1;
            if (st.timeout)
            begin
                cmd.abort      = 1'b1;
                cmd.abort_code = STAT_TIMEOUT;
                cmd.go_idle    = 1'b1;
                state_next     = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/scf_dp.sv
// ----------------------------------------------------------------------------
// scf_dp
// Frame store, write pointer, silence timer, readout pipeline, result register.
// ----------------------------------------------------------------------------
module scf_dp #(
    parameter int SHORT_FRAME_LEN = scf_pkg::SHORT_FRAME_LEN_DEF,
    parameter int LONG_FRAME_LEN  = scf_pkg::LONG_FRAME_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scf_pkg::cfg_t              cfg,
    input  scf_pkg::cmd_t              cmd,
    output scf_pkg::stat_t             st,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [7:0]                 frame_byte,
    output logic [scf_pkg::ADDR_W-1:0] byte_pos,
    output logic                       long_frame,
    output logic                       last
);
    import scf_pkg::*;

    localparam logic [ADDR_W-1:0] SHORT_LAST = ADDR_W'(clamp_len(SHORT_FRAME_LEN) - 1);
    localparam logic [ADDR_W-1:0] LONG_LAST  = ADDR_W'(clamp_len(LONG_FRAME_LEN) - 1);

    logic [7:0]        store_mem [STORE_DEPTH];

    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic              is_long_reg;
    logic              is_long_next;
    logic [15:0]       silence_reg;
    logic [15:0]       silence_next;
    logic              timer_run_reg;
    logic              timer_run_next;

    logic              emit_active_reg;
    logic              emit_active_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] rd_addr_next;
    logic              issued_all_reg;
    logic              issued_all_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_pos_reg;
    logic              rd_last_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_status_reg;
    logic [7:0]        out_byte_reg;
    logic [ADDR_W-1:0] out_pos_reg;
    logic              out_long_reg;
    logic              out_last_reg;

    logic [ADDR_W-1:0] len_last;
    logic [ADDR_W-1:0] byte_len_last;
    logic [ADDR_W:0]   wp_plus;
    logic [15:0]       silence_inc;
    logic [15:0]       limit;
    logic              byte_long;
    logic              out_free;
    logic              out_from_rd;
    logic              issue;

    assign byte_long     = (rx_byte >= LONG_CMD_MIN);
    assign len_last      = is_long_reg ? LONG_LAST : SHORT_LAST;
    assign byte_len_last = byte_long ? LONG_LAST : SHORT_LAST;
    assign wp_plus       = {1'b0, wp_reg} + (ADDR_W+1)'(1);
    assign silence_inc   = (silence_reg == 16'hFFFF) ? silence_reg : silence_reg + 16'd1;
    assign limit         = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_from_rd = rd_valid_reg && out_free;
    assign issue       = emit_active_reg && !issued_all_reg && (!rd_valid_reg || out_from_rd);

    assign st.byte_is_start = (rx_byte == cfg.start_marker);
    assign st.byte_is_end   = (rx_byte == cfg.end_marker);
    assign st.start_to_end  = (byte_len_last <= ADDR_W'(2));
    assign st.payload_last  = (wp_plus >= {1'b0, len_last});
    assign st.timeout       = timer_run_reg && (silence_inc >= limit);
    assign st.emit_done     = out_from_rd && rd_last_reg;
    assign st.out_free      = out_free;

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign frame_byte = out_byte_reg;
    assign byte_pos   = out_pos_reg;
    assign long_frame = out_long_reg;
    assign last       = out_last_reg;

    always_comb
    begin
        wp_next        = wp_reg;
        is_long_next   = is_long_reg;
        silence_next   = silence_reg;
        timer_run_next = timer_run_reg;
        if (cmd.wp_inc)
        begin
            wp_next = wp_plus[ADDR_W-1:0];
        end
        if (cmd.long_load)
        begin
            is_long_next = byte_long;
        end
        if (cmd.timer_restart)
        begin
            silence_next   = 16'd0;
            timer_run_next = 1'b1;
        end
        else if (cmd.timer_tick && timer_run_reg)
        begin
            silence_next = silence_inc;
        end
        if (cmd.go_idle)
        begin
            wp_next        = '0;
            is_long_next   = 1'b0;
            silence_next   = 16'd0;
            timer_run_next = 1'b0;
        end
    end

    always_comb
    begin
        emit_active_next = emit_active_reg;
        rd_addr_next     = rd_addr_reg;
        issued_all_next  = issued_all_reg;
        rd_valid_next    = rd_valid_reg;
        if (cmd.emit_start)
        begin
            emit_active_next = 1'b1;
            rd_addr_next     = '0;
            issued_all_next  = 1'b0;
        end
        if (st.emit_done)
        begin
            emit_active_next = 1'b0;
        end
        if (issue)
        begin
            rd_addr_next    = rd_addr_reg + ADDR_W'(1);
            issued_all_next = (rd_addr_reg == len_last);
            rd_valid_next   = 1'b1;
        end
        else if (out_from_rd)
        begin
            rd_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.abort || out_from_rd)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            is_long_reg     <= 1'b0;
            silence_reg     <= 16'd0;
            timer_run_reg   <= 1'b0;
            emit_active_reg <= 1'b0;
            rd_addr_reg     <= '0;
            issued_all_reg  <= 1'b0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            wp_reg          <= wp_next;
            is_long_reg     <= is_long_next;
            silence_reg     <= silence_next;
            timer_run_reg   <= timer_run_next;
            emit_active_reg <= emit_active_next;
            rd_addr_reg     <= rd_addr_next;
            issued_all_reg  <= issued_all_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            store_mem[wp_reg] <= rx_byte;
        end
        if (issue)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
            rd_pos_reg  <= rd_addr_reg;
            rd_last_reg <= (rd_addr_reg == len_last);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.abort)
        begin
            out_status_reg <= cmd.abort_code;
            out_byte_reg   <= 8'd0;
            out_pos_reg    <= wp_reg;
            out_long_reg   <= is_long_reg;
            out_last_reg   <= 1'b1;
        end
        else if (out_from_rd)
        begin
            out_status_reg <= STAT_FRAME;
            out_byte_reg   <= rd_data_reg;
            out_pos_reg    <= rd_pos_reg;
            out_long_reg   <= is_long_reg;
            out_last_reg   <= rd_last_reg;
        end
    end

    a_timer_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        timer_run_reg |-> (wp_reg != '0))
        else $error("timer running with no open frame");

    a_no_abort_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        emit_active_reg |-> (!cmd.abort && !cmd.store_wr))
        else $error("store written or abort raised during readout");

    a_issue_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> rd_valid_reg)
        else $error("issued read did not fill the read stage");

    a_last_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_FRAME && out_last_reg)
            |-> (out_pos_reg == (out_long_reg ? LONG_LAST : SHORT_LAST)))
        else $error("frame last marker at wrong position");

endmodule

// File: hdl/serial_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Start/command/end byte deframer with a tick-based silence timeout.
// ----------------------------------------------------------------------------
// Flow: a byte or tick is taken when offered while in_stall is low; an abort result is
// registered and shown in the cycle after its item; good frame bytes pass the read stage
// and result register. Throughput: one item per cycle unless the output stalls; an end
// byte closing a good frame blocks input while the single store read port reads it out.
// Reset: asynchronous, clears phase, pointer, timer and result valid; the store is
// left uninitialized and needs no clearing pass.
module serial_command_frame_receiver #(
    parameter int SHORT_FRAME_LEN = scf_pkg::SHORT_FRAME_LEN_DEF,
    parameter int LONG_FRAME_LEN  = scf_pkg::LONG_FRAME_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scf_pkg::PADDR_W-1:0] paddr,
    input  logic [scf_pkg::PDATA_W-1:0] pwdata,
    output logic [scf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [7:0]                  frame_byte,
    output logic [scf_pkg::ADDR_W-1:0]  byte_pos,
    output logic                        long_frame,
    output logic                        last
);
    import scf_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t st;

    scf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    scf_dp #(
        .SHORT_FRAME_LEN (SHORT_FRAME_LEN),
        .LONG_FRAME_LEN  (LONG_FRAME_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .st         (st),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .frame_byte (frame_byte),
        .byte_pos   (byte_pos),
        .long_frame (long_frame),
        .last       (last)
    );

endmodule
